/* rtl/apr_pkg.sv */
// shared types and constants of the aging page replacement table
`timescale 1ns / 1ps

package apr_pkg;

  localparam int TABLE_ENTRIES = 16;
  localparam int SLOT_W        = $clog2(TABLE_ENTRIES);
  localparam int ID_BITS       = 8;
  localparam int AGE_W         = 8;
  localparam int PERIOD_W      = 8;
  localparam int MODE_W        = 3;
  localparam int STATUS_W      = 2;
  localparam int PADDR_W       = 3;

  localparam logic [PERIOD_W-1:0] PERIOD_RESET = PERIOD_W'(8);

  typedef enum logic [MODE_W-1:0] {
    MODE_HIT    = 3'd0,
    MODE_INSERT = 3'd1,
    MODE_EVICT  = 3'd2,
    MODE_REMOVE = 3'd3,
    MODE_TICK   = 3'd4
  } apr_mode_e;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK        = 2'd0,
    STAT_NOT_FOUND = 2'd1,
    STAT_FULL      = 2'd2,
    STAT_EMPTY     = 2'd3
  } apr_status_e;

  // input transaction
  typedef struct packed {
    logic [MODE_W-1:0]  mode;
    logic [ID_BITS-1:0] page_id;
  } apr_in_t;

  // result transaction
  typedef struct packed {
    logic [ID_BITS-1:0]  victim_id;
    logic [STATUS_W-1:0] status;
  } apr_out_t;

  // per-cell update strobes
  typedef struct packed {
    logic ins;
    logic set_ref;
    logic kill;
    logic age;
  } apr_cell_ctl_t;

  // best victim so far, handed from cell to cell
  typedef struct packed {
    logic               found;
    logic               ref_bit;
    logic [AGE_W-1:0]   age;
    logic [ID_BITS-1:0] id;
    logic [SLOT_W-1:0]  slot;
  } apr_cand_t;

endpackage

/* rtl/apr_cell.sv */
// one table entry with its stage of the victim search chain
`timescale 1ns / 1ps

module apr_cell import apr_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [SLOT_W-1:0]  slot_i,
  input  apr_cell_ctl_t      ctl_i,
  input  logic [ID_BITS-1:0] id_i,
  input  apr_cand_t          cand_i,
  output apr_cand_t          cand_o,
  output logic               valid_o,
  output logic               match_o
);

  logic               valid_q, valid_d;
  logic               ref_q, ref_d;
  logic [AGE_W-1:0]   age_q, age_d;
  logic [ID_BITS-1:0] id_q, id_d;
  apr_cand_t          cand_q, cand_d;
  logic               own_better;

  always_comb begin
    valid_d = valid_q;
    ref_d   = ref_q;
    age_d   = age_q;
    id_d    = id_q;
    if (ctl_i.ins) begin
      valid_d = 1'b1;
      id_d    = id_i;
      ref_d   = 1'b0;
      age_d   = '0;
    end else if (ctl_i.kill) begin
      valid_d = 1'b0;
      ref_d   = 1'b0;
      age_d   = '0;
    end else if (ctl_i.set_ref) begin
      ref_d = 1'b1;
    end else if (ctl_i.age && valid_q) begin
      age_d = {ref_q, age_q[AGE_W-1:1]};
      ref_d = 1'b0;
    end
  end

  // clear reference bit first, then smaller age, then smaller id
  always_comb begin
    own_better = (!ref_q && cand_i.ref_bit) ||
                 ((ref_q == cand_i.ref_bit) &&
                  ((age_q < cand_i.age) || ((age_q == cand_i.age) && (id_q < cand_i.id))));
    cand_d = cand_i;
    if (valid_q && (!cand_i.found || own_better)) begin
      cand_d.found   = 1'b1;
      cand_d.ref_bit = ref_q;
      cand_d.age     = age_q;
      cand_d.id      = id_q;
      cand_d.slot    = slot_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      ref_q   <= 1'b0;
      age_q   <= '0;
      cand_q  <= '0;
    end else begin
      valid_q <= valid_d;
      ref_q   <= ref_d;
      age_q   <= age_d;
      cand_q  <= cand_d;
    end
  end

  always_ff @(posedge clk_i) begin
    id_q <= id_d;
  end

  assign cand_o  = cand_q;
  assign valid_o = valid_q;
  assign match_o = valid_q && (id_q == id_i);

endmodule

/* rtl/aging_page_replacement_table.sv */
// top level of the aging page replacement table
`timescale 1ns / 1ps

// channel     | direction | handshake                    | payload
// ------------+-----------+------------------------------+---------------------------
// command     | in        | start high, busy low         | cmd_i (mode, page_id)
// result      | out       | done_o strobe, one cycle     | result_o (victim_id, status)
// config      | in/out    | apb psel/penable/pwrite      | sample_period at byte 0
//
// hit, insert, remove and tick: the accept registers the command, then the EXEC
//   state decodes it, updates the entries and registers the result strobe
// evict: EXEC hands over to SCAN, where the victim search walks the cell chain
//   one cell per cycle; the result strobe is registered once all cells are walked
// reset clears all valid, reference and age bits at once; no clearing pass
// the receiver cannot stall: each result is shown for exactly one cycle

module aging_page_replacement_table import apr_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  apr_in_t            cmd_i,
  output logic               done_o,
  output apr_out_t           result_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_EXEC = 3'b010,
    S_SCAN = 3'b100
  } apr_state_e;

  apr_state_e state_q, state_d;

  // command register, held for the whole transaction
  apr_in_t cmd_q;

  // configuration and tick counter
  logic [PERIOD_W-1:0] period_q;
  logic [PERIOD_W-1:0] tick_q, tick_d;
  logic [PERIOD_W:0]   tick_inc;
  logic                age_now;

  // scan counter
  logic [SLOT_W-1:0] cnt_q, cnt_d;
  logic              scan_done;

  // result registers
  logic     done_q, done_d;
  apr_out_t res_q, res_d;

  // cell chain wiring
  apr_cand_t                  cand [TABLE_ENTRIES+1];
  apr_cell_ctl_t              ctl  [TABLE_ENTRIES];
  logic [TABLE_ENTRIES-1:0]   valid_vec;
  logic [TABLE_ENTRIES-1:0]   match_vec;
  logic [TABLE_ENTRIES-1:0]   free_vec;
  logic [TABLE_ENTRIES-1:0]   free_oh;
  logic                       hit_any;
  logic                       exec;
  apr_cand_t                  best;

  assign cand[0] = '0;   // head of the chain: nothing found yet
  assign best    = cand[TABLE_ENTRIES];

  for (genvar k = 0; k < TABLE_ENTRIES; k++) begin : g_cell
    apr_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .slot_i  (SLOT_W'(k)),
      .ctl_i   (ctl[k]),
      .id_i    (cmd_q.page_id),
      .cand_i  (cand[k]),
      .cand_o  (cand[k+1]),
      .valid_o (valid_vec[k]),
      .match_o (match_vec[k])
    );
  end

  assign exec      = (state_q == S_EXEC);
  assign hit_any   = |match_vec;
  assign free_vec  = ~valid_vec;
  // lowest free slot as a one-hot vector
  assign free_oh   = free_vec & (~free_vec + TABLE_ENTRIES'(1));
  assign scan_done = (state_q == S_SCAN) && (cnt_q == SLOT_W'(TABLE_ENTRIES - 1));

  // aging fires when the incremented count reaches or passes the period
  assign tick_inc = {1'b0, tick_q} + (PERIOD_W + 1)'(1);
  assign age_now  = (tick_inc >= {1'b0, period_q});

  // per-cell update strobes
  always_comb begin
    for (int k = 0; k < TABLE_ENTRIES; k++) begin
      ctl[k].ins     = exec && (cmd_q.mode == MODE_INSERT) && !hit_any && free_oh[k];
      ctl[k].set_ref = exec && (cmd_q.mode == MODE_HIT) && match_vec[k];
      ctl[k].kill    = (exec && (cmd_q.mode == MODE_REMOVE) && match_vec[k]) ||
                       (scan_done && best.found && (best.slot == SLOT_W'(k)));
      ctl[k].age     = exec && (cmd_q.mode == MODE_TICK) && age_now;
    end
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    tick_d  = tick_q;
    done_d  = 1'b0;
    res_d   = res_q;
    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        res_d.victim_id = '0;
        res_d.status    = STAT_OK;
        if (cmd_q.mode == MODE_EVICT) begin
          // let the chain settle over every cell before trusting its tail
          state_d = S_SCAN;
          cnt_d   = '0;
        end else begin
          state_d = S_IDLE;
          done_d  = 1'b1;
          case (cmd_q.mode) inside
            MODE_HIT, MODE_REMOVE: begin
              if (!hit_any) begin
                res_d.status = STAT_NOT_FOUND;
              end
            end
            MODE_INSERT: begin
              if (!hit_any && !(|free_vec)) begin
                res_d.status = STAT_FULL;
              end
            end
            MODE_TICK: begin
              tick_d = age_now ? '0 : tick_inc[PERIOD_W-1:0];
            end
            default: begin
            end
          endcase
        end
      end
      S_SCAN: begin
        cnt_d = cnt_q + SLOT_W'(1);
        if (scan_done) begin
          state_d = S_IDLE;
          done_d  = 1'b1;
          if (best.found) begin
            res_d.victim_id = best.id;
            res_d.status    = STAT_OK;
          end else begin
            res_d.victim_id = '0;
            res_d.status    = STAT_EMPTY;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      cnt_q    <= '0;
      tick_q   <= '0;
      done_q   <= 1'b0;
      period_q <= PERIOD_RESET;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      tick_q  <= tick_d;
      done_q  <= done_d;
      // sample_period write, low address bits ignored
      if (psel && penable && pwrite && !paddr[2]) begin
        period_q <= pwdata[PERIOD_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
    if (state_q == S_IDLE && start) begin
      cmd_q <= cmd_i;
    end
  end

  assign busy     = (state_q != S_IDLE);
  assign done_o   = done_q;
  assign result_o = res_q;
  assign pready   = 1'b1;
  assign prdata   = paddr[2] ? 32'd0 : {{(32 - PERIOD_W){1'b0}}, period_q};

endmodule

/* rtl/apr_checker.sv */
// port-level checks for the aging page replacement table
`timescale 1ns / 1ps

module apr_checker import apr_pkg::*; (
  input logic     clk_i,
  input logic     rst_ni,
  input logic     start,
  input logic     busy,
  input apr_in_t  cmd_i,
  input logic     done_o,
  input apr_out_t result_o
);

  // accepted transaction makes the block busy
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy)
    else $error("busy not raised after accept");

  // every command other than evict is answered on done_o after its accept
  a_short_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && (cmd_i.mode != MODE_EVICT) |-> ##2 done_o)
    else $error("result missing two cycles after accept");

  // the result strobe comes with the block idle and lasts one cycle
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy ##1 !done_o)
    else $error("result strobe while busy or longer than one cycle");

  // an empty table never reports a victim
  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && (result_o.status == STAT_EMPTY) |-> (result_o.victim_id == '0))
    else $error("victim reported with empty status");

endmodule

bind aging_page_replacement_table apr_checker u_apr_checker (
  .clk_i    (clk_i),
  .rst_ni   (rst_ni),
  .start    (start),
  .busy     (busy),
  .cmd_i    (cmd_i),
  .done_o   (done_o),
  .result_o (result_o)
);
